// ===== rtl/ftx_pkg.sv =====
package ftx_pkg;

  typedef enum logic [1:0] {
    REQ_CREATE  = 2'd0,
    REQ_DESTROY = 2'd1,
    REQ_WAIT    = 2'd2,
    REQ_WAKE    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BUSY       = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_QUEUE_FULL = 3'd4
  } status_t;

  localparam int IdW   = 30;
  localparam int ProcW = 16;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IdW-1:0]   lock_id;
    logic [ProcW-1:0] process;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IdW-1:0]   new_id;
    logic             wake_valid;
    logic [ProcW-1:0] woken_process;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE_SCAN,
    S_CAND_SCAN,
    S_LOOKUP,
    S_LOOK_RD,
    S_EXEC,
    S_WAKE_RD,
    S_WAKE_WAIT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the request
    logic scan_clr;   // reset scan index and flags
    logic scan_step;  // visit one slot
    logic cand_next;  // advance create candidate
    logic rd_slot;    // read slot record at found slot
    logic do_create;
    logic do_destroy;
    logic do_enq;
    logic do_deq_rd;  // issue waiter read
    logic do_deq;     // finish the dequeue
    logic set_result;
    logic [2:0] res_status;
  } ftx_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic scan_last;
    logic hit;        // candidate/id matched a live slot
    logic free_found;
    logic cand_fail;  // candidate tries exhausted
    logic cnt_zero;
    logic cnt_full;
  } ftx_sts_t;

endpackage

// ===== rtl/ftx_datapath.sv =====
module ftx_datapath
  import ftx_pkg::*;
#(
  parameter int NUM_FUTEXES       = 256,
  parameter int WAITERS_PER_FUTEX = 16,
  parameter int ID_LIMIT          = 1073741824
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_beat_t  in_beat,
  input  ftx_cmd_t  cmd,
  output ftx_sts_t  sts,
  output out_beat_t res
);

  localparam int SW = (NUM_FUTEXES > 1) ? $clog2(NUM_FUTEXES) : 1;
  localparam int QW = (WAITERS_PER_FUTEX > 1) ? $clog2(WAITERS_PER_FUTEX) : 1;
  localparam int CW = $clog2(WAITERS_PER_FUTEX + 1);
  localparam int TSW = CW + 1;
  localparam int TW = $clog2(NUM_FUTEXES + 2);
  localparam int EW = $clog2(NUM_FUTEXES + 1);
  localparam int WD = NUM_FUTEXES * (1 << QW);
  localparam int WA = SW + QW;
  localparam logic [IdW-1:0] IdMax = IdW'(ID_LIMIT - 1);

  // slot record memory: id, count, head
  logic [IdW-1:0] id_mem   [NUM_FUTEXES];
  logic [CW-1:0]  cnt_mem  [NUM_FUTEXES];
  logic [QW-1:0]  head_mem [NUM_FUTEXES];
  logic [ProcW-1:0] wait_mem [WD];
  logic [NUM_FUTEXES-1:0] used_r, used_nxt;

  in_beat_t       req_r;
  logic [SW-1:0]  idx_r, idx_nxt;
  logic [SW-1:0]  free_r, free_nxt;
  logic           free_found_r, free_found_nxt;
  logic [SW-1:0]  slot_r, slot_nxt;
  logic           hit_r, hit_nxt;
  logic [IdW-1:0] cand_r, cand_nxt;
  logic [TW-1:0]  tries_r, tries_nxt;
  logic [IdW-1:0] last_id_r, last_id_nxt;
  logic [EW-1:0]  used_cnt_r, used_cnt_nxt;
  logic [IdW-1:0] rd_id_r;
  logic [CW-1:0]  rd_cnt_r;
  logic [QW-1:0]  rd_head_r;
  logic [ProcW-1:0] rd_wait_r;
  out_beat_t      res_r, res_nxt;

  logic [IdW-1:0] key;
  logic [IdW-1:0] cand_inc;
  logic [TSW-1:0] tail_sum;
  logic [QW-1:0]  tail;
  logic [QW-1:0]  head_inc;

  assign key      = (req_r.req_type == REQ_CREATE) ? cand_r : req_r.lock_id;
  assign cand_inc = (cand_r == IdMax) ? '0 : cand_r + 1'b1;
  // ring position wraps with one compare and subtract
  assign tail_sum = TSW'(rd_head_r) + TSW'(rd_cnt_r);
  assign tail     = (tail_sum >= TSW'(WAITERS_PER_FUTEX)) ?
                    QW'(tail_sum - TSW'(WAITERS_PER_FUTEX)) : QW'(tail_sum);
  assign head_inc = (rd_head_r == QW'(WAITERS_PER_FUTEX - 1)) ? '0 : rd_head_r + 1'b1;

  // registered read of scanned (or found) slot id
  always_ff @(posedge clk) begin
    rd_id_r <= id_mem[cmd.rd_slot ? slot_r : idx_r];
    rd_cnt_r  <= cnt_mem[slot_r];
    rd_head_r <= head_mem[slot_r];
    rd_wait_r <= wait_mem[{slot_r, rd_head_r}];
    if (cmd.do_create) begin
      id_mem[free_r]   <= cand_r;
      cnt_mem[free_r]  <= '0;
      head_mem[free_r] <= '0;
    end
    if (cmd.do_enq) begin
      wait_mem[WA'({slot_r, tail})] <= req_r.process;
      cnt_mem[slot_r] <= rd_cnt_r + 1'b1;
    end
    if (cmd.do_deq) begin
      cnt_mem[slot_r]  <= rd_cnt_r - 1'b1;
      head_mem[slot_r] <= head_inc;
    end
    if (cmd.capture) req_r <= in_beat;
    res_r <= res_nxt;
  end

  // scan pipeline: idx_r is read this cycle, compared the next
  logic [SW-1:0] cmp_idx_r;
  logic          cmp_v_r;
  logic          sent_last_r;  // last index already issued
  logic          scan_done_r;  // last compare has settled into the flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0; last_id_r <= '0; used_cnt_r <= '0;
      cmp_v_r <= 1'b0; sent_last_r <= 1'b0; scan_done_r <= 1'b0;
    end else begin
      used_r <= used_nxt; last_id_r <= last_id_nxt; used_cnt_r <= used_cnt_nxt;
      cmp_v_r <= cmd.scan_step && !sent_last_r;
      scan_done_r <= cmp_v_r && cmp_idx_r == SW'(NUM_FUTEXES - 1);
      if (cmd.scan_clr) sent_last_r <= 1'b0;
      else if (cmd.scan_step && idx_r == SW'(NUM_FUTEXES - 1)) sent_last_r <= 1'b1;
    end
    cmp_idx_r <= idx_r;
    idx_r <= idx_nxt; free_r <= free_nxt; free_found_r <= free_found_nxt;
    slot_r <= slot_nxt; hit_r <= hit_nxt; cand_r <= cand_nxt; tries_r <= tries_nxt;
  end

  always_comb begin
    idx_nxt = idx_r; free_nxt = free_r; free_found_nxt = free_found_r;
    slot_nxt = slot_r; hit_nxt = hit_r; cand_nxt = cand_r; tries_nxt = tries_r;
    used_nxt = used_r; last_id_nxt = last_id_r; used_cnt_nxt = used_cnt_r;
    res_nxt = res_r;
    if (cmd.capture) begin
      cand_nxt  = (last_id_r == IdMax) ? '0 : last_id_r + 1'b1;
      tries_nxt = '0;
    end
    if (cmd.scan_clr) begin
      idx_nxt = '0; hit_nxt = 1'b0; free_found_nxt = 1'b0;
    end
    if (cmd.scan_step && idx_r != SW'(NUM_FUTEXES - 1)) idx_nxt = idx_r + 1'b1;
    if (cmp_v_r) begin
      if (!used_r[cmp_idx_r] && !free_found_r) begin
        free_found_nxt = 1'b1; free_nxt = cmp_idx_r;
      end
      if (used_r[cmp_idx_r] && rd_id_r == key) begin
        hit_nxt = 1'b1; slot_nxt = cmp_idx_r;
      end
    end
    if (cmd.cand_next) begin
      cand_nxt = cand_inc; tries_nxt = tries_r + 1'b1;
    end
    if (cmd.do_create) begin
      used_nxt[free_r] = 1'b1; used_cnt_nxt = used_cnt_r + 1'b1; last_id_nxt = cand_r;
    end
    if (cmd.do_destroy) begin
      used_nxt[slot_r] = 1'b0;
      if (used_cnt_r != '0) used_cnt_nxt = used_cnt_r - 1'b1;
    end
    if (cmd.set_result) begin
      res_nxt = '0;
      res_nxt.status = cmd.res_status;
      if (cmd.do_create) res_nxt.new_id = cand_r;
      if (cmd.do_deq) begin
        res_nxt.wake_valid = 1'b1; res_nxt.woken_process = rd_wait_r;
      end
    end
  end

  // scan finished the cycle after the last index has been compared
  assign sts.req_type   = req_r.req_type;
  assign sts.scan_last  = scan_done_r;
  assign sts.hit        = hit_r;
  assign sts.free_found = free_found_r;
  assign sts.cand_fail  = tries_r == TW'(NUM_FUTEXES);
  assign sts.cnt_zero   = rd_cnt_r == '0;
  assign sts.cnt_full   = rd_cnt_r >= CW'(WAITERS_PER_FUTEX);
  assign res = res_r;

endmodule

// ===== rtl/ftx_ctrl.sv =====
module ftx_ctrl
  import ftx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  ftx_sts_t sts,
  output ftx_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic   last_seen;

  assign last_seen = sts.scan_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid && !in_stall) state_nxt = S_FREE_SCAN;
      S_FREE_SCAN: begin
        if (last_seen) begin
          if (sts.req_type != REQ_CREATE) state_nxt = sts.hit ? S_LOOK_RD : S_DONE;
          else if (!sts.free_found) state_nxt = S_DONE;
          else if (!sts.hit) state_nxt = S_DONE;
          else if (sts.cand_fail) state_nxt = S_DONE;
          else state_nxt = S_CAND_SCAN;
        end
      end
      S_CAND_SCAN: state_nxt = S_FREE_SCAN;
      S_LOOK_RD:   state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.req_type == REQ_WAKE && !sts.cnt_zero) state_nxt = S_WAKE_RD;
        else state_nxt = S_DONE;
      end
      S_WAKE_RD:   state_nxt = S_WAKE_WAIT;
      S_WAKE_WAIT: state_nxt = S_DONE;
      S_DONE:      state_nxt = S_IDLE;
      S_LOOKUP:    state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    ov_nxt = ov_r && out_stall;
    case (state_r)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.capture = 1'b1; cmd.scan_clr = 1'b1;
      end
      S_FREE_SCAN: begin
        cmd.scan_step = !last_seen;
        if (last_seen) begin
          if (sts.req_type != REQ_CREATE) begin
            if (!sts.hit) begin
              cmd.set_result = 1'b1; cmd.res_status = ST_NOT_FOUND;
            end else cmd.rd_slot = 1'b1;
          end else if (!sts.free_found) begin
            cmd.set_result = 1'b1; cmd.res_status = ST_TABLE_FULL;
          end else if (!sts.hit) begin
            cmd.do_create = 1'b1; cmd.set_result = 1'b1; cmd.res_status = ST_OK;
          end else if (sts.cand_fail) begin
            cmd.set_result = 1'b1; cmd.res_status = ST_TABLE_FULL;
          end else cmd.cand_next = 1'b1;
        end
      end
      S_CAND_SCAN: cmd.scan_clr = 1'b1;
      S_EXEC: begin
        case (sts.req_type)
          REQ_DESTROY: begin
            cmd.set_result = 1'b1;
            if (sts.cnt_zero) begin
              cmd.do_destroy = 1'b1; cmd.res_status = ST_OK;
            end else cmd.res_status = ST_BUSY;
          end
          REQ_WAIT: begin
            cmd.set_result = 1'b1;
            if (sts.cnt_full) cmd.res_status = ST_QUEUE_FULL;
            else begin
              cmd.do_enq = 1'b1; cmd.res_status = ST_OK;
            end
          end
          REQ_WAKE: begin
            if (sts.cnt_zero) begin
              cmd.set_result = 1'b1; cmd.res_status = ST_OK;
            end else cmd.do_deq_rd = 1'b1;
          end
          default: ;
        endcase
      end
      S_WAKE_WAIT: begin
        cmd.do_deq = 1'b1; cmd.set_result = 1'b1; cmd.res_status = ST_OK;
      end
      S_DONE: ov_nxt = 1'b1;
      default: ;
    endcase
  end

  // candidate-scan state restarts the scan index after the candidate bump
  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;

endmodule

// ===== rtl/futex_table_fifo_waiters.sv =====
// Futex lock manager with FIFO wait queues. One request beat in, one result
// beat out. Every request walks the whole slot table once (one slot record
// read per cycle, then the last compare settles) to find the addressed id and
// the first free slot; a create repeats that walk, plus a restart step, for
// each candidate id that is already live; most creates need only one walk.
// After a hit the found slot record is read, then the table or queue is
// updated (a wake reads the waiter first) and the result beat is driven.
// A new request is taken only once the previous result has been taken.
module futex_table_fifo_waiters
  import ftx_pkg::*;
#(
  parameter int NUM_FUTEXES       = 256,
  parameter int WAITERS_PER_FUTEX = 16,
  parameter int ID_LIMIT          = 1073741824
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  ftx_cmd_t cmd;
  ftx_sts_t sts;

  // sequencer
  ftx_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  // table, queues and result register
  ftx_datapath #(
    .NUM_FUTEXES(NUM_FUTEXES),
    .WAITERS_PER_FUTEX(WAITERS_PER_FUTEX),
    .ID_LIMIT(ID_LIMIT)
  ) u_dp (
    .clk, .rst_n, .in_beat(in_data), .cmd, .sts, .res(out_data)
  );

`ifndef SYNTH
  // no new beat while a result is pending
  a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open with result pending");
  // result payload stays while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data)) else $error("result moved");
  // wake flag only on ok status
  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.wake_valid |-> out_data.status == ST_OK)
    else $error("wake with error status");
`endif

endmodule
